// ----- sv/ppdc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ppdc_pkg
// Shared types, widths and constants of the polar pose docking controller.
// ============================================================================
package ppdc_pkg;

    localparam int POS_W      = 32;
    localparam int HEAD_W     = 15;
    localparam int GAIN_W     = 16;
    localparam int LIN_W      = 31;
    localparam int ANGL_W     = 15;
    localparam int OUT_V_W    = 32;
    localparam int OUT_W_W    = 16;
    localparam int DIFF_W     = POS_W + 1;
    localparam int GUARD_SH   = 8;
    localparam int X_W        = 44;
    localparam int Z_W        = 35;
    localparam int RHO_W      = 34;
    localparam int A_W        = 18;
    localparam int V_W        = 42;
    localparam int W_W        = 25;
    localparam int MA_W       = 45;
    localparam int MB_W       = 25;
    localparam int MP_W       = MA_W + MB_W;
    localparam int P_W        = 60;
    localparam int Q_W        = 32;
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [A_W-1:0] PI_A      = A_W'(12868);
    localparam logic signed [A_W-1:0] HALF_PI_A = A_W'(6434);
    localparam logic signed [A_W-1:0] TWO_PI_A  = A_W'(25736);
    localparam logic signed [Z_W-1:0] PI_Z      = Z_W'(64'd3373259426);
    localparam logic [RHO_W-1:0]      DZ_ENTER  = RHO_W'(1311);
    localparam logic [RHO_W-1:0]      DZ_LEAVE  = RHO_W'(3277);
    localparam logic [GAIN_W-1:0]     INV_HI    = GAIN_W'(39796);
    localparam logic [GAIN_W-1:0]     INV_LO    = GAIN_W'(60840);

    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_HEAD = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_A    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_B    = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_LIN_LIM   = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_ANG_LIM   = CFG_IDX_W'(7);

    localparam logic [LIN_W-1:0]  LIN_LIM_RST = LIN_W'(131072);
    localparam logic [ANGL_W-1:0] ANG_LIM_RST = ANGL_W'(25736);

    typedef struct packed {
        logic signed [POS_W-1:0]  goal_x;
        logic signed [POS_W-1:0]  goal_y;
        logic signed [HEAD_W-1:0] goal_heading;
        logic [GAIN_W-1:0]        gain_distance;
        logic [GAIN_W-1:0]        gain_alpha;
        logic signed [GAIN_W-1:0] gain_beta;
        logic [LIN_W-1:0]         linear_limit;
        logic [ANGL_W-1:0]        angular_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [OUT_V_W-1:0] linear_velocity;
        logic signed [OUT_W_W-1:0] angular_velocity;
        logic                      in_deadzone;
    } res_t;

    function automatic logic [30:0] atan_lut(input logic [ATAN_IDX_W-1:0] i);
        logic [30:0] r;
        case (i)
            5'd0:    r = 31'd843314857;
            5'd1:    r = 31'd497837829;
            5'd2:    r = 31'd263043836;
            5'd3:    r = 31'd133525158;
            5'd4:    r = 31'd67021686;
            5'd5:    r = 31'd33543515;
            5'd6:    r = 31'd16775850;
            5'd7:    r = 31'd8388437;
            5'd8:    r = 31'd4194282;
            5'd9:    r = 31'd2097149;
            5'd10:   r = 31'd1048575;
            5'd11:   r = 31'd524287;
            5'd12:   r = 31'd262143;
            5'd13:   r = 31'd131071;
            5'd14:   r = 31'd65535;
            5'd15:   r = 31'd32767;
            5'd16:   r = 31'd16383;
            5'd17:   r = 31'd8191;
            5'd18:   r = 31'd4095;
            5'd19:   r = 31'd2047;
            5'd20:   r = 31'd1023;
            5'd21:   r = 31'd511;
            5'd22:   r = 31'd255;
            5'd23:   r = 31'd127;
            default: r = 31'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [A_W-1:0] wrap_ang(input logic signed [A_W-1:0] a);
        logic signed [A_W-1:0] r;
        r = a;
        if (r >= TWO_PI_A) begin
            r = r - TWO_PI_A;
        end else if (r <= -TWO_PI_A) begin
            r = r + TWO_PI_A;
        end
        if (r > PI_A) begin
            r = r - TWO_PI_A;
        end else if (r < -PI_A) begin
            r = r + TWO_PI_A;
        end
        return r;
    endfunction

endpackage

// ----- sv/ppdc_cordic.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ppdc_cordic
// Vectoring CORDIC, one micro-rotation per cycle: magnitude and bearing.
// ============================================================================
module ppdc_cordic
    import ppdc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    output logic                     done,
    output logic signed [X_W-1:0]    x_out,
    output logic signed [Z_W-1:0]    z_out
);

    localparam int N_ITER = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam logic [ATAN_IDX_W-1:0] LAST = ATAN_IDX_W'(N_ITER - 1);

    logic signed [X_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0] z_reg, z_next;
    logic [ATAN_IDX_W-1:0] i_reg, i_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic signed [X_W-1:0] gx, gy, sx, sy;
    logic signed [Z_W-1:0] atan_z;

    always_comb begin
        gx = $signed({{(X_W-DIFF_W-GUARD_SH){dx[DIFF_W-1]}}, dx, {GUARD_SH{1'b0}}});
        gy = $signed({{(X_W-DIFF_W-GUARD_SH){dy[DIFF_W-1]}}, dy, {GUARD_SH{1'b0}}});
        sx = x_reg >>> i_reg;
        sy = y_reg >>> i_reg;
        atan_z = $signed({{(Z_W-31){1'b0}}, atan_lut(i_reg)});
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            i_next = '0;
            if (gx < 0) begin
                z_next = (gy >= 0) ? PI_Z : -PI_Z;
                x_next = -gx;
                y_next = -gy;
            end else begin
                z_next = '0;
                x_next = gx;
                y_next = gy;
            end
        end else if (busy_reg) begin
            if (y_reg >= 0) begin
                x_next = x_reg + sy;
                y_next = y_reg - sx;
                z_next = z_reg + atan_z;
            end else begin
                x_next = x_reg - sy;
                y_next = y_reg + sx;
                z_next = z_reg - atan_z;
            end
            i_next = i_reg + 1'b1;
            if (i_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign z_out = z_reg;

endmodule

// ----- sv/ppdc_divider.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ppdc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module ppdc_divider
    import ppdc_pkg::*;
#(
    parameter int DVD_W = P_W,
    parameter int DVS_W = V_W,
    parameter int QT_W  = Q_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [QT_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(QT_W + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QT_W - 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [QT_W-1:0]  lo_reg, lo_next;
    logic [QT_W-1:0]  q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;

    always_comb begin
        trial = {rem_reg, lo_reg[QT_W-1]};
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        lo_next = lo_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = DVS_W'(dividend[DVD_W-1:QT_W]);
            lo_next = dividend[QT_W-1:0];
            dvs_next = divisor;
            q_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                q_next = {q_reg[QT_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_W-1:0];
                q_next = {q_reg[QT_W-2:0], 1'b0};
            end
            lo_next = {lo_reg[QT_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- sv/ppdc_seq.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ppdc_seq
// Control sequencer: drives the CORDIC, a shared registered multiplier and
// the divider through rho, alpha, beta, the commands and their limiting.
// ============================================================================
module ppdc_seq
    import ppdc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     start,
    output logic                     idle,
    input  logic signed [POS_W-1:0]  robot_x,
    input  logic signed [POS_W-1:0]  robot_y,
    input  logic signed [HEAD_W-1:0] robot_heading,
    input  logic                     controller_active,
    output logic                     res_valid,
    input  logic                     res_ready,
    output res_t                     res
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CORD = 4'd1;
    localparam logic [3:0] ST_RHO1 = 4'd2;
    localparam logic [3:0] ST_RHO2 = 4'd3;
    localparam logic [3:0] ST_RHO3 = 4'd4;
    localparam logic [3:0] ST_V1   = 4'd5;
    localparam logic [3:0] ST_V2   = 4'd6;
    localparam logic [3:0] ST_W0   = 4'd7;
    localparam logic [3:0] ST_W1   = 4'd8;
    localparam logic [3:0] ST_W2   = 4'd9;
    localparam logic [3:0] ST_LIM  = 4'd10;
    localparam logic [3:0] ST_CMP1 = 4'd11;
    localparam logic [3:0] ST_CMP2 = 4'd12;
    localparam logic [3:0] ST_CMP3 = 4'd13;
    localparam logic [3:0] ST_DIVW = 4'd14;
    localparam logic [3:0] ST_FIN  = 4'd15;

    logic [3:0]            state_reg, state_next;
    logic                  dz_reg, dz_next;
    logic signed [A_W-1:0] rh_reg, rh_next;
    logic signed [A_W-1:0] theta_reg, theta_next;
    logic signed [A_W-1:0] alpha_reg, alpha_next;
    logic signed [A_W-1:0] beta_reg, beta_next;
    logic [RHO_W-1:0]      rho_reg, rho_next;
    logic signed [V_W-1:0] v_reg, v_next;
    logic signed [W_W-1:0] w_reg, w_next;
    logic signed [P_W-1:0] acc_reg, acc_next;
    logic signed [P_W-1:0] p_reg;
    logic                  lin_reg, lin_next;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;

    logic                     cor_start, cor_done;
    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [X_W-1:0]    cor_x;
    logic signed [Z_W-1:0]    cor_z;

    logic             div_start, div_done;
    logic [P_W-1:0]   div_dvd;
    logic [V_W-1:0]   div_dvs;
    logic [Q_W-1:0]   div_q;

    logic signed [Z_W-1:0] z_rnd;
    logic signed [A_W-1:0] bearing;
    logic signed [P_W-1:0] sum;
    logic [RHO_W-1:0]      rho_raw;
    logic signed [V_W-1:0] v_mul;
    logic [V_W-1:0]        av;
    logic [W_W-1:0]        aw;
    logic signed [V_W-1:0] lin_s;
    logic signed [W_W-1:0] ang_s;

    assign dx = $signed({cfg.goal_x[POS_W-1], cfg.goal_x})
              - $signed({robot_x[POS_W-1], robot_x});
    assign dy = $signed({cfg.goal_y[POS_W-1], cfg.goal_y})
              - $signed({robot_y[POS_W-1], robot_y});
    assign cor_start = start && controller_active;

    ppdc_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cor_start),
        .dx     (dx),
        .dy     (dy),
        .done   (cor_done),
        .x_out  (cor_x),
        .z_out  (cor_z)
    );

    ppdc_divider #(
        .DVD_W(P_W),
        .DVS_W(V_W),
        .QT_W (Q_W)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dvd),
        .divisor (div_dvs),
        .done    (div_done),
        .quotient(div_q)
    );

    always_comb begin
        av = (v_reg < 0) ? V_W'(-v_reg) : V_W'(v_reg);
        aw = (w_reg < 0) ? W_W'(-w_reg) : W_W'(w_reg);
        lin_s = $signed(V_W'(cfg.linear_limit));
        ang_s = $signed(W_W'(cfg.angular_limit));
        z_rnd = cor_z + $signed(Z_W'(64'h20000));
        bearing = A_W'($signed(z_rnd[Z_W-1:18]));
        sum = acc_reg + (p_reg >>> 16);
        rho_raw = sum[RHO_W+23:24];
        v_mul = p_reg[V_W+7:8];
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RHO1: begin
                mul_a = MA_W'(cor_x);
                mul_b = $signed(MB_W'(INV_HI));
            end
            ST_RHO2: begin
                mul_a = MA_W'(cor_x);
                mul_b = $signed(MB_W'(INV_LO));
            end
            ST_V1: begin
                mul_a = $signed(MA_W'(rho_reg));
                mul_b = $signed(MB_W'(cfg.gain_distance));
            end
            ST_W0: begin
                mul_a = dz_reg ? MA_W'(-theta_reg) : MA_W'(alpha_reg);
                mul_b = $signed(MB_W'(cfg.gain_alpha));
            end
            ST_W1: begin
                mul_a = MA_W'(beta_reg);
                mul_b = MB_W'(cfg.gain_beta);
            end
            ST_CMP1: begin
                mul_a = $signed(MA_W'(cfg.linear_limit));
                mul_b = $signed(MB_W'(aw));
            end
            ST_CMP2: begin
                mul_a = $signed(MA_W'(av));
                mul_b = $signed(MB_W'(cfg.angular_limit));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        state_next = state_reg;
        dz_next = dz_reg;
        rh_next = rh_reg;
        theta_next = theta_reg;
        alpha_next = alpha_reg;
        beta_next = beta_reg;
        rho_next = rho_reg;
        v_next = v_reg;
        w_next = w_reg;
        acc_next = acc_reg;
        lin_next = lin_reg;
        div_start = 1'b0;
        div_dvd = lin_reg ? P_W'(acc_reg) : P_W'(p_reg);
        div_dvs = lin_reg ? av : V_W'(aw);
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    rh_next = A_W'(robot_heading);
                    theta_next = A_W'(robot_heading) - A_W'(cfg.goal_heading);
                    if (controller_active) begin
                        state_next = ST_CORD;
                    end else begin
                        v_next = '0;
                        w_next = '0;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_CORD: begin
                if (cor_done) begin
                    state_next = ST_RHO1;
                end
            end
            ST_RHO1: begin
                alpha_next = wrap_ang(bearing - rh_reg);
                state_next = ST_RHO2;
            end
            ST_RHO2: begin
                acc_next = p_reg;
                state_next = ST_RHO3;
            end
            ST_RHO3: begin
                if (rho_raw < DZ_ENTER) begin
                    dz_next = 1'b1;
                end else if (rho_raw > DZ_LEAVE) begin
                    dz_next = 1'b0;
                end
                rho_next = dz_next ? '0 : rho_raw;
                state_next = ST_V1;
            end
            ST_V1: begin
                state_next = ST_V2;
            end
            ST_V2: begin
                if (alpha_reg <= HALF_PI_A && alpha_reg > -HALF_PI_A) begin
                    v_next = v_mul;
                end else begin
                    v_next = -v_mul;
                    alpha_next = (alpha_reg > HALF_PI_A) ? alpha_reg - PI_A
                                                         : alpha_reg + PI_A;
                end
                state_next = ST_W0;
            end
            ST_W0: begin
                beta_next = wrap_ang(-theta_reg - alpha_reg);
                state_next = ST_W1;
            end
            ST_W1: begin
                if (dz_reg) begin
                    w_next = p_reg[W_W+7:8];
                    state_next = ST_LIM;
                end else begin
                    acc_next = p_reg;
                    state_next = ST_W2;
                end
            end
            ST_W2: begin
                w_next = W_W'((acc_reg + p_reg) >>> 8);
                state_next = ST_LIM;
            end
            ST_LIM: begin
                if ((V_W'(aw) > V_W'(cfg.angular_limit)) || (av > V_W'(cfg.linear_limit))) begin
                    state_next = ST_CMP1;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_CMP1: begin
                state_next = ST_CMP2;
            end
            ST_CMP2: begin
                acc_next = p_reg;
                state_next = ST_CMP3;
            end
            ST_CMP3: begin
                if (av == '0) begin
                    lin_next = 1'b0;
                end else if (aw == '0) begin
                    lin_next = 1'b1;
                end else begin
                    lin_next = (acc_reg <= p_reg);
                end
                div_start = 1'b1;
                div_dvd = lin_next ? P_W'(acc_reg) : P_W'(p_reg);
                div_dvs = lin_next ? av : V_W'(aw);
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_done) begin
                    if (lin_reg) begin
                        w_next = (w_reg < 0) ? -W_W'(div_q) : W_W'(div_q);
                        v_next = (v_reg < 0) ? -lin_s : lin_s;
                    end else begin
                        v_next = (v_reg < 0) ? -V_W'(div_q) : V_W'(div_q);
                        w_next = (w_reg < 0) ? -ang_s : ang_s;
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dz_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            dz_reg    <= dz_next;
        end
        rh_reg    <= rh_next;
        theta_reg <= theta_next;
        alpha_reg <= alpha_next;
        beta_reg  <= beta_next;
        rho_reg   <= rho_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
        acc_reg   <= acc_next;
        lin_reg   <= lin_next;
        p_reg     <= mul_p[P_W-1:0];
    end

    assign idle = (state_reg == ST_IDLE);
    assign res.linear_velocity  = v_reg[OUT_V_W-1:0];
    assign res.angular_velocity = w_reg[OUT_W_W-1:0];
    assign res.in_deadzone      = dz_reg;

endmodule

// ----- sv/polar_pose_docking_controller_top.sv -----
`timescale 1ns / 1ps
// An inactive pose goes straight to the result; an active pose runs the CORDIC and,
// when a limit applies, the divider as well.
// Throughput: a pose is taken only while the sequencer is idle, one pose at a time;
// the next pose is taken while the previous result waits in the output register.
// Reset: synchronous active low; clears the deadzone state and loads the
// configuration reset values (limits 2.0 m/s and 2pi rad/s).
// ============================================================================
// polar_pose_docking_controller_top
// Polar pose stabilization controller: config registers, sequencer, output.
// ============================================================================
module polar_pose_docking_controller_top
    import ppdc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [POS_W-1:0]    s_robot_x,
    input  logic signed [POS_W-1:0]    s_robot_y,
    input  logic signed [HEAD_W-1:0]   s_robot_heading,
    input  logic                       s_controller_active,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_V_W-1:0]  m_linear_velocity,
    output logic signed [OUT_W_W-1:0]  m_angular_velocity,
    output logic                       m_in_deadzone
);

    cfg_t cfg_reg;
    res_t out_reg;
    res_t res;
    logic m_valid_reg;
    logic res_valid, res_ready, idle, start;

    assign cfg_ready = 1'b1;
    assign s_ready   = idle;
    assign start     = s_valid && idle;
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.goal_x        <= '0;
            cfg_reg.goal_y        <= '0;
            cfg_reg.goal_heading  <= '0;
            cfg_reg.gain_distance <= '0;
            cfg_reg.gain_alpha    <= '0;
            cfg_reg.gain_beta     <= '0;
            cfg_reg.linear_limit  <= LIN_LIM_RST;
            cfg_reg.angular_limit <= ANG_LIM_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GOAL_X:    cfg_reg.goal_x        <= cfg_data;
                REG_GOAL_Y:    cfg_reg.goal_y        <= cfg_data;
                REG_GOAL_HEAD: cfg_reg.goal_heading  <= cfg_data[HEAD_W-1:0];
                REG_GAIN_D:    cfg_reg.gain_distance <= cfg_data[GAIN_W-1:0];
                REG_GAIN_A:    cfg_reg.gain_alpha    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_B:    cfg_reg.gain_beta     <= cfg_data[GAIN_W-1:0];
                REG_LIN_LIM:   cfg_reg.linear_limit  <= cfg_data[LIN_W-1:0];
                REG_ANG_LIM:   cfg_reg.angular_limit <= cfg_data[ANGL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ppdc_seq #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .start            (start),
        .idle             (idle),
        .robot_x          (s_robot_x),
        .robot_y          (s_robot_y),
        .robot_heading    (s_robot_heading),
        .controller_active(s_controller_active),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_linear_velocity  = out_reg.linear_velocity;
    assign m_angular_velocity = out_reg.angular_velocity;
    assign m_in_deadzone      = out_reg.in_deadzone;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sequencer still idle after taking a word");

    a_ang_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angular_velocity <= $signed({1'b0, cfg_reg.angular_limit}))
                 && (m_angular_velocity >= -$signed({1'b0, cfg_reg.angular_limit})))
        else $error("angular command beyond limit");

    a_lin_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_linear_velocity <= $signed({1'b0, cfg_reg.linear_limit}))
                 && (m_linear_velocity >= -$signed({1'b0, cfg_reg.linear_limit})))
        else $error("linear command beyond limit");

endmodule
